### src/dmpq_pkg.sv
// ----------------------------------------------------------------------------
// dmpq_pkg
// Shared types and constants for the deletable minimum priority queue.
// ----------------------------------------------------------------------------
package dmpq_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_ERASE = 2'd1,
    OP_POP   = 2'd2
  } dmpq_op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } dmpq_status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
  } dmpq_in_t;

  typedef struct packed {
    logic [31:0] popped_key;
    logic [31:0] min_key;
    logic [6:0]  live_count;
    logic [1:0]  status;
  } dmpq_out_t;

  // operation broadcast to every cell, already qualified
  typedef struct packed {
    logic push;
    logic erase;
    logic pop;
  } dmpq_cmd_t;

  // what a cell tells its right-hand neighbour
  typedef struct packed {
    logic valid;
    logic gt;
  } dmpq_flags_t;

endpackage

### src/dmpq_cell.sv
// ----------------------------------------------------------------------------
// dmpq_cell
// One slot of the sorted chain: holds a key and a valid flag, and moves
// keys to or from its neighbours on push, erase and pop.
// ----------------------------------------------------------------------------
module dmpq_cell #(
  parameter int unsigned KEY_WIDTH = dmpq_pkg::KEY_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dmpq_pkg::dmpq_cmd_t   cmd_i,
  input  logic [KEY_WIDTH-1:0]  key_i,
  input  dmpq_pkg::dmpq_flags_t left_flags_i,
  input  logic [KEY_WIDTH-1:0]  left_key_i,
  input  logic                  right_valid_i,
  input  logic [KEY_WIDTH-1:0]  right_key_i,
  output dmpq_pkg::dmpq_flags_t flags_o,
  output logic                  eq_o,
  output logic [KEY_WIDTH-1:0]  key_o
);

  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 valid_q, valid_d;
  logic                 gt, ge;

  assign gt   = valid_q && (key_q > key_i);
  assign ge   = valid_q && (key_q >= key_i);
  assign eq_o = valid_q && (key_q == key_i);

  assign flags_o.valid = valid_q;
  assign flags_o.gt    = gt;
  assign key_o         = key_q;

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (cmd_i.push) begin
      if (gt || (!valid_q && left_flags_i.valid)) begin
        key_d   = left_flags_i.gt ? left_key_i : key_i;
        valid_d = 1'b1;
      end
    end else if (cmd_i.pop || (cmd_i.erase && ge)) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

### src/deletable_min_priority_queue.sv
// ----------------------------------------------------------------------------
// deletable_min_priority_queue
// Sorted multiset of keys in a chain of cells; push, erase one, pop minimum.
// ----------------------------------------------------------------------------
// Result: done_o is strobed in the cycle after the start transfer.
// Throughput: one item per cycle; every cell shifts in the same cycle, so
// busy never rises.
// Reset: all cell valid flags and the count clear at once; queue empty.
// Results cannot be stalled by the receiver.
module deletable_min_priority_queue #(
  parameter int unsigned CAPACITY  = dmpq_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = dmpq_pkg::KEY_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  dmpq_pkg::dmpq_in_t  in_i,
  output logic                done_o,
  output dmpq_pkg::dmpq_out_t out_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                       accept;
  logic [KEY_WIDTH-1:0]       key;
  logic [63:0]                key_ext;
  logic [63:0]                min_ext;
  dmpq_pkg::dmpq_cmd_t        cmd;
  dmpq_pkg::dmpq_flags_t      flags [CAPACITY];
  logic [KEY_WIDTH-1:0]       keys  [CAPACITY];
  logic [CAPACITY-1:0]        eq;
  logic                       found, full, empty;
  logic [CW-1:0]              count_q, count_d;
  logic                       done_q;
  logic [31:0]                popped_q, popped_d;
  dmpq_pkg::dmpq_status_e     status_q, status_d;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign key_ext = 64'(in_i.key);
  assign key     = key_ext[KEY_WIDTH-1:0];
  assign found   = |eq;
  assign full    = (count_q == CW'(CAPACITY));
  assign empty   = (count_q == '0);

  always_comb begin
    cmd      = '0;
    count_d  = count_q;
    popped_d = '0;
    status_d = dmpq_pkg::ST_OK;
    min_ext  = 64'(keys[0]);
    if (accept) begin
      case (in_i.operation)
        dmpq_pkg::OP_PUSH: begin
          if (full) begin
            status_d = dmpq_pkg::ST_FULL;
          end else begin
            cmd.push = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        dmpq_pkg::OP_ERASE: begin
          if (found) begin
            cmd.erase = 1'b1;
            count_d   = count_q - CW'(1);
          end else begin
            status_d = dmpq_pkg::ST_ABSENT;
          end
        end
        dmpq_pkg::OP_POP: begin
          if (empty) begin
            status_d = dmpq_pkg::ST_EMPTY;
          end else begin
            cmd.pop  = 1'b1;
            count_d  = count_q - CW'(1);
            popped_d = min_ext[31:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    dmpq_pkg::dmpq_flags_t left_flags;
    logic [KEY_WIDTH-1:0]  left_key;
    logic                  right_valid;
    logic [KEY_WIDTH-1:0]  right_key;

    if (g == 0) begin : g_head
      assign left_flags = '{valid: 1'b1, gt: 1'b0};
      assign left_key   = '0;
    end else begin : g_body
      assign left_flags = flags[g-1];
      assign left_key   = keys[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_key   = '0;
    end else begin : g_inner
      assign right_valid = flags[g+1].valid;
      assign right_key   = keys[g+1];
    end

    dmpq_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .key_i        (key),
      .left_flags_i (left_flags),
      .left_key_i   (left_key),
      .right_valid_i(right_valid),
      .right_key_i  (right_key),
      .flags_o      (flags[g]),
      .eq_o         (eq[g]),
      .key_o        (keys[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= dmpq_pkg::ST_OK;
    end else begin
      count_q  <= count_d;
      done_q   <= accept;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
  end

  assign done_o           = done_q;
  assign out_o.popped_key = popped_q;
  assign out_o.min_key    = empty ? 32'd0 : min_ext[31:0];
  assign out_o.live_count = 7'(count_q);
  assign out_o.status     = status_q;

endmodule

### bench/deletable_min_priority_queue_test.sv
// ----------------------------------------------------------------------------
// deletable_min_priority_queue_test
// Self-checking bench for the deletable minimum priority queue. A short table
// of directed transfers covers empty and extreme keys, duplicates, the unused
// operation code and the ok, empty and absent statuses. It is followed by
// about 900 random transfers in fill, drain and mixed bursts, so the queue
// runs full and empty many times. Every result is checked against a
// sorted-queue predictor, or against the value typed into the table.
// ----------------------------------------------------------------------------
module deletable_min_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY     = dmpq_pkg::CAPACITY_DEF;
  localparam logic [1:0]  OP_NONE      = 2'd3;
  localparam int          N_DIRECTED   = 24;
  localparam int          RANDOM_ITEMS = 900;
  localparam int          CYCLE_LIMIT  = 200000;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } burst_mode_e;

  typedef struct packed {
    dmpq_pkg::dmpq_in_t  item;
    logic                typed;
    dmpq_pkg::dmpq_out_t want;
  } directed_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  dmpq_pkg::dmpq_in_t  in_i;
  logic                done_o;
  dmpq_pkg::dmpq_out_t out_o;

  // typed expectation travelling with the item on the input side
  logic                row_typed;
  dmpq_pkg::dmpq_out_t row_want;

  logic [31:0]         live_keys[$];
  dmpq_pkg::dmpq_out_t expected_results[$];

  int unsigned idle_pct = 12;
  int unsigned mismatch_count = 0;
  int unsigned transfer_count = 0;
  int unsigned result_count = 0;
  int unsigned peak_occupancy = 0;
  int unsigned cycle_count = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  directed_row_t directed_rows [N_DIRECTED];

  deletable_min_priority_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .out_o  (out_o)
  );

  always #2 clk_i = ~clk_i;

  // Sorted multiset: apply one operation, return what the queue reports.
  function automatic dmpq_pkg::dmpq_out_t apply_item(input dmpq_pkg::dmpq_in_t item);
    dmpq_pkg::dmpq_out_t    res;
    dmpq_pkg::dmpq_status_e st;
    int                     pos;
    res = '0;
    st  = dmpq_pkg::ST_OK;
    case (item.operation)
      dmpq_pkg::OP_PUSH: begin
        if (live_keys.size() >= CAPACITY) begin
          st = dmpq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < live_keys.size() && live_keys[pos] <= item.key) pos++;
          live_keys.insert(pos, item.key);
        end
      end
      dmpq_pkg::OP_ERASE: begin
        st = dmpq_pkg::ST_ABSENT;
        for (pos = 0; pos < live_keys.size(); pos++) begin
          if (live_keys[pos] == item.key) begin
            live_keys.delete(pos);
            st = dmpq_pkg::ST_OK;
            break;
          end
        end
      end
      dmpq_pkg::OP_POP: begin
        if (live_keys.size() == 0) begin
          st = dmpq_pkg::ST_EMPTY;
        end else begin
          res.popped_key = live_keys.pop_front();
        end
      end
      default: ;
    endcase
    res.min_key    = (live_keys.size() != 0) ? live_keys[0] : 32'd0;
    res.live_count = 7'(live_keys.size());
    res.status     = st;
    return res;
  endfunction

  task automatic compare_result(input dmpq_pkg::dmpq_out_t want,
                                input dmpq_pkg::dmpq_out_t got);
    if (got.popped_key !== want.popped_key) begin
      $error("popped_key: expected %h, actual %h", want.popped_key, got.popped_key);
      mismatch_count++;
    end
    if (got.min_key !== want.min_key) begin
      $error("min_key: expected %h, actual %h", want.min_key, got.min_key);
      mismatch_count++;
    end
    if (got.live_count !== want.live_count) begin
      $error("live_count: expected %0d, actual %0d", want.live_count, got.live_count);
      mismatch_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      mismatch_count++;
    end
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($urandom_range(0, 20));
    if (r < 7) return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    return $urandom();
  endfunction

  function automatic dmpq_pkg::dmpq_in_t make_item(input burst_mode_e mode);
    dmpq_pkg::dmpq_in_t item;
    int unsigned        r;
    r = $urandom_range(0, 99);
    item.key = pick_key();
    case (mode)
      MODE_FILL:  item.operation = (r < 75) ? dmpq_pkg::OP_PUSH :
                                   (r < 87) ? dmpq_pkg::OP_ERASE :
                                   (r < 97) ? dmpq_pkg::OP_POP : OP_NONE;
      MODE_DRAIN: item.operation = (r < 15) ? dmpq_pkg::OP_PUSH :
                                   (r < 35) ? dmpq_pkg::OP_ERASE :
                                   (r < 97) ? dmpq_pkg::OP_POP : OP_NONE;
      default:    item.operation = (r < 40) ? dmpq_pkg::OP_PUSH :
                                   (r < 68) ? dmpq_pkg::OP_ERASE :
                                   (r < 95) ? dmpq_pkg::OP_POP : OP_NONE;
    endcase
    // mostly erase something that is actually queued
    if (item.operation == dmpq_pkg::OP_ERASE && live_keys.size() != 0 &&
        $urandom_range(0, 9) < 7) begin
      item.key = live_keys[$urandom_range(0, live_keys.size() - 1)];
    end
    return item;
  endfunction

  // Called at a falling edge; returns at the rising edge of the transfer.
  task automatic send_item(input dmpq_pkg::dmpq_in_t item, input logic typed,
                           input dmpq_pkg::dmpq_out_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start     <= 1'b1;
    in_i      <= item;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk_i); while (busy);
  endtask

  always @(posedge clk_i) begin
    dmpq_pkg::dmpq_out_t predicted;
    dmpq_pkg::dmpq_out_t oldest;
    if (rst_ni) begin
      if (start && !busy) begin
        predicted = apply_item(in_i);
        expected_results = {expected_results, (row_typed ? row_want : predicted)};
        status_seen[predicted.status]++;
        if (live_keys.size() > peak_occupancy) peak_occupancy = live_keys.size();
        transfer_count++;
      end
      if (done_o) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $error("result with no transfer outstanding");
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          compare_result(oldest, out_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    burst_mode_e mode;
    int unsigned burst_len;
    int unsigned burst_no;
    int unsigned random_sent;

    start     = 1'b0;
    in_i      = '0;
    row_typed = 1'b0;
    row_want  = '0;
    rst_ni    = 1'b0;

    directed_rows = '{
      '{'{dmpq_pkg::OP_POP,   32'd0},         1'b1,
        '{32'd0, 32'd0, 7'd0, dmpq_pkg::ST_EMPTY}},
      '{'{dmpq_pkg::OP_ERASE, 32'd5},         1'b1,
        '{32'd0, 32'd0, 7'd0, dmpq_pkg::ST_ABSENT}},
      '{'{OP_NONE,            32'hFFFF_FFFF}, 1'b1,
        '{32'd0, 32'd0, 7'd0, dmpq_pkg::ST_OK}},
      '{'{dmpq_pkg::OP_PUSH,  32'hFFFF_FFFF}, 1'b1,
        '{32'd0, 32'hFFFF_FFFF, 7'd1, dmpq_pkg::ST_OK}},
      '{'{dmpq_pkg::OP_PUSH,  32'd0},         1'b1,
        '{32'd0, 32'd0, 7'd2, dmpq_pkg::ST_OK}},
      '{'{dmpq_pkg::OP_PUSH,  32'd0},         1'b1,
        '{32'd0, 32'd0, 7'd3, dmpq_pkg::ST_OK}},
      '{'{dmpq_pkg::OP_ERASE, 32'd0},         1'b1,
        '{32'd0, 32'd0, 7'd2, dmpq_pkg::ST_OK}},
      '{'{dmpq_pkg::OP_ERASE, 32'd5},         1'b1,
        '{32'd0, 32'd0, 7'd2, dmpq_pkg::ST_ABSENT}},
      '{'{dmpq_pkg::OP_POP,   32'd0},         1'b1,
        '{32'd0, 32'hFFFF_FFFF, 7'd1, dmpq_pkg::ST_OK}},
      '{'{OP_NONE,            32'd0},         1'b1,
        '{32'd0, 32'hFFFF_FFFF, 7'd1, dmpq_pkg::ST_OK}},
      '{'{dmpq_pkg::OP_POP,   32'd0},         1'b1,
        '{32'hFFFF_FFFF, 32'd0, 7'd0, dmpq_pkg::ST_OK}},
      '{'{dmpq_pkg::OP_POP,   32'hFFFF_FFFF}, 1'b1,
        '{32'd0, 32'd0, 7'd0, dmpq_pkg::ST_EMPTY}},
      '{'{dmpq_pkg::OP_PUSH,  32'h8000_0000}, 1'b0, '0},
      '{'{dmpq_pkg::OP_PUSH,  32'd7},         1'b0, '0},
      '{'{dmpq_pkg::OP_PUSH,  32'd7},         1'b0, '0},
      '{'{dmpq_pkg::OP_PUSH,  32'h7FFF_FFFF}, 1'b0, '0},
      '{'{dmpq_pkg::OP_PUSH,  32'd3},         1'b0, '0},
      '{'{dmpq_pkg::OP_ERASE, 32'd7},         1'b0, '0},
      '{'{dmpq_pkg::OP_ERASE, 32'h8000_0000}, 1'b0, '0},
      '{'{dmpq_pkg::OP_POP,   32'd0},         1'b0, '0},
      '{'{dmpq_pkg::OP_POP,   32'd0},         1'b0, '0},
      '{'{dmpq_pkg::OP_ERASE, 32'd7},         1'b0, '0},
      '{'{dmpq_pkg::OP_POP,   32'd0},         1'b0, '0},
      '{'{dmpq_pkg::OP_ERASE, 32'h5555_5555}, 1'b0, '0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      @(negedge clk_i);
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // a long fill to capacity and a long drain past empty, then random bursts
    burst_no    = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (burst_no)
        0: begin
          mode      = MODE_FILL;
          burst_len = 150;
        end
        1: begin
          mode      = MODE_DRAIN;
          burst_len = 150;
        end
        default: begin
          mode      = burst_mode_e'($urandom_range(0, 2));
          burst_len = $urandom_range(20, 120);
        end
      endcase
      for (int i = 0; i < burst_len && random_sent < RANDOM_ITEMS; i++) begin
        idle_pct = (random_sent >= 400 && random_sent < 600) ? 0 : 12;
        @(negedge clk_i);
        send_item(make_item(mode), 1'b0, '0);
        random_sent++;
      end
      burst_no++;
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Covered %0d transfers and %0d results; peak occupancy %0d of %0d.",
             transfer_count, result_count, peak_occupancy, CAPACITY);
    $display("Status mix: ok %0d, pop on empty %0d, push when full %0d, erase absent %0d.",
             status_seen[dmpq_pkg::ST_OK], status_seen[dmpq_pkg::ST_EMPTY],
             status_seen[dmpq_pkg::ST_FULL], status_seen[dmpq_pkg::ST_ABSENT]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
